// ===== design/bcp_pkg.sv =====
package bcp_pkg;

   localparam int COORD_W = 32;
   localparam int BOUND_W = 34;
   localparam int EDGE_W  = 32;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 240;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [BOUND_W-1:0] bound_type;
   typedef logic        [EDGE_W-1:0]  edge_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   typedef struct packed {
      point_type lo;
      point_type hi;
   } box_type;

   typedef struct packed {
      bound_type min_x;
      bound_type min_y;
      bound_type min_z;
      bound_type max_x;
      bound_type max_y;
      bound_type max_z;
      edge_type  edge_len;
   } cube_type;

   typedef struct packed {
      logic vld;
      logic take;
   } link_type;

endpackage

// ===== design/bounding_cube_of_points_top.sv =====
// Path: a last-marked point accepted on req_ passes the input register, the box register and
// the result register, waiting where the next one is still full, before its cube shows on rsp_.
// Throughput: one point per cycle while req_tready is high; the running min/max update is the feedback loop.
// A waiting result does not block input until the box register is also full, and then only a last point waits.
// Reset clears all valid flags and the open-set flag; no clearing pass is needed.
module bounding_cube_of_points_top import bcp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // pos_x, pos_y, pos_z
   input  logic                  req_tlast,  // last_point
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // cube_min_x, cube_min_y, cube_min_z, cube_max_x, cube_max_y, cube_max_z, cube_edge, zeros
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic      in_vld_ff;
   point_type in_pt_ff;
   logic      in_last_ff;
   logic      pt_take;
   link_type  box_link;
   logic      box_take;
   box_type   box;
   cube_type  cube;

   assign req_tready = !in_vld_ff || pt_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_pt_ff.x <= req_tdata[31:0];
         in_pt_ff.y <= req_tdata[63:32];
         in_pt_ff.z <= req_tdata[95:64];
         in_last_ff <= req_tlast;
      end
   end

   bcp_track u_track (
      .clock      (clock),
      .reset      (reset),
      .pt_vld     (in_vld_ff),
      .pt         (in_pt_ff),
      .pt_last    (in_last_ff),
      .pt_take    (pt_take),
      .box_link_o (box_link),
      .box_take   (box_take),
      .box        (box)
   );

   bcp_cube u_cube (
      .clock     (clock),
      .reset     (reset),
      .box_link  (box_link),
      .box       (box),
      .box_take  (box_take),
      .cube_vld  (rsp_tvalid),
      .cube_take (rsp_tready),
      .cube      (cube)
   );

   assign rsp_tdata = {4'b0000, cube.edge_len, cube.max_z, cube.max_y, cube.max_x,
                       cube.min_z, cube.min_y, cube.min_x};

endmodule

// ===== design/bcp_track.sv =====
module bcp_track import bcp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      pt_vld,
   input  point_type pt,
   input  logic      pt_last,
   output logic      pt_take,
   output link_type  box_link_o,
   input  logic      box_take,
   output box_type   box
);

   point_type lo_ff, hi_ff, lo_in, hi_in;
   logic      started_ff;
   logic      box_vld_ff;
   box_type   box_ff;

   function automatic coord_type pick_lo(coord_type p, coord_type cur, logic started);
      pick_lo = (!started || (p < cur)) ? p : cur;
   endfunction

   function automatic coord_type pick_hi(coord_type p, coord_type cur, logic started);
      pick_hi = (!started || (p > cur)) ? p : cur;
   endfunction

   always_comb begin
      lo_in.x = pick_lo(pt.x, lo_ff.x, started_ff);
      lo_in.y = pick_lo(pt.y, lo_ff.y, started_ff);
      lo_in.z = pick_lo(pt.z, lo_ff.z, started_ff);
      hi_in.x = pick_hi(pt.x, hi_ff.x, started_ff);
      hi_in.y = pick_hi(pt.y, hi_ff.y, started_ff);
      hi_in.z = pick_hi(pt.z, hi_ff.z, started_ff);
   end

   // a last beat needs the box slot free or draining
   assign pt_take = pt_vld && (!pt_last || !box_vld_ff || box_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         box_vld_ff <= 1'b0;
      end else begin
         if (pt_take) begin
            started_ff <= !pt_last;
         end
         if (pt_take && pt_last) begin
            box_vld_ff <= 1'b1;
         end else if (box_take) begin
            box_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pt_take) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
      if (pt_take && pt_last) begin
         box_ff.lo <= lo_in;
         box_ff.hi <= hi_in;
      end
   end

   assign box_link_o.vld  = box_vld_ff;
   assign box_link_o.take = box_take;
   assign box             = box_ff;

   a_box_ordered: assert property (@(posedge clock) disable iff (reset)
      box_vld_ff |-> (box_ff.lo.x <= box_ff.hi.x) && (box_ff.lo.y <= box_ff.hi.y)
                     && (box_ff.lo.z <= box_ff.hi.z))
      else $error("box bounds out of order");

   a_new_set: assert property (@(posedge clock) disable iff (reset)
      (pt_take && pt_last) |=> !started_ff && box_vld_ff)
      else $error("last beat did not close the set");

endmodule

// ===== design/bcp_cube.sv =====
module bcp_cube import bcp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  link_type box_link,
   input  box_type  box,
   output logic     box_take,
   output logic     cube_vld,
   input  logic     cube_take,
   output cube_type cube
);

   logic signed [COORD_W:0] dx, dy, dz;
   edge_type  ex, ey, ez, edge_in, pad_x, pad_y, pad_z;
   cube_type  cube_in, cube_ff;
   logic      vld_ff;

   always_comb begin
      dx = {box.hi.x[COORD_W-1], box.hi.x} - {box.lo.x[COORD_W-1], box.lo.x};
      dy = {box.hi.y[COORD_W-1], box.hi.y} - {box.lo.y[COORD_W-1], box.lo.y};
      dz = {box.hi.z[COORD_W-1], box.hi.z} - {box.lo.z[COORD_W-1], box.lo.z};
      ex = dx[EDGE_W-1:0];
      ey = dy[EDGE_W-1:0];
      ez = dz[EDGE_W-1:0];
      edge_in = ex;
      if (ey > edge_in) begin
         edge_in = ey;
      end
      if (ez > edge_in) begin
         edge_in = ez;
      end
      pad_x = (edge_in - ex) >> 1;
      pad_y = (edge_in - ey) >> 1;
      pad_z = (edge_in - ez) >> 1;
      cube_in.min_x = BOUND_W'(box.lo.x) - bound_type'({2'b00, pad_x});
      cube_in.min_y = BOUND_W'(box.lo.y) - bound_type'({2'b00, pad_y});
      cube_in.min_z = BOUND_W'(box.lo.z) - bound_type'({2'b00, pad_z});
      cube_in.max_x = BOUND_W'(box.hi.x) + bound_type'({2'b00, pad_x});
      cube_in.max_y = BOUND_W'(box.hi.y) + bound_type'({2'b00, pad_y});
      cube_in.max_z = BOUND_W'(box.hi.z) + bound_type'({2'b00, pad_z});
      cube_in.edge_len = edge_in;
   end

   assign box_take = box_link.vld && (!vld_ff || cube_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (box_take) begin
         vld_ff <= 1'b1;
      end else if (cube_take) begin
         vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (box_take) begin
         cube_ff <= cube_in;
      end
   end

   assign cube_vld = vld_ff;
   assign cube     = cube_ff;

   logic signed [BOUND_W:0] span_x, span_y, span_z, edge_s;
   assign span_x = (BOUND_W+1)'(cube_ff.max_x) - (BOUND_W+1)'(cube_ff.min_x);
   assign span_y = (BOUND_W+1)'(cube_ff.max_y) - (BOUND_W+1)'(cube_ff.min_y);
   assign span_z = (BOUND_W+1)'(cube_ff.max_z) - (BOUND_W+1)'(cube_ff.min_z);
   assign edge_s = (BOUND_W+1)'({3'b000, cube_ff.edge_len});

   a_span_x: assert property (@(posedge clock) disable iff (reset)
      vld_ff |-> (span_x == edge_s) || (span_x == edge_s - 1))
      else $error("x span off the cube edge");

   a_span_yz: assert property (@(posedge clock) disable iff (reset)
      vld_ff |-> ((span_y == edge_s) || (span_y == edge_s - 1))
                 && ((span_z == edge_s) || (span_z == edge_s - 1)))
      else $error("y or z span off the cube edge");

endmodule
